### hdl/assert_macros.svh
// Assertion macros shared by the sprite projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is masked while reset is high.
`define RSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define RSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/rsp_pkg.sv
// Shared types and constants of the sprite projection pipeline.
`timescale 1ns / 1ps
package rsp_pkg;

  // Divider lane sizes: numerator, divisor, one quotient bit per stage.
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_LAT   = DIV_NUM_W;
  localparam int FRONT_LAT = 6;
  localparam int BACK_LAT  = 2;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT;
  localparam int DIV_LANES = 3;

  // Lane numbers of the divider bank.
  localparam int LANE_DEPTH = 0;
  localparam int LANE_COL   = 1;
  localparam int LANE_SIZE  = 2;

  // Register reset values.
  localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd640;
  localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

  // Reciprocal of five for the sneak scaling of the bottom row.
  localparam logic [15:0] DIV5_MULT  = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_index_t;

  // Control bits that travel beside the divider lanes.
  typedef struct packed {
    logic valid;
    logic sneak;
    logic det_zero;
    logic neg_depth;
    logic neg_col;
  } rsp_side_t;

endpackage

### hdl/rsp_front.sv
// Front stages: offsets, camera products, sums, magnitudes and divider operands.
`timescale 1ns / 1ps
module rsp_front import rsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    sprite_pos_x,
  input  logic signed [15:0]    sprite_pos_y,
  input  logic signed [15:0]    viewer_pos_x,
  input  logic signed [15:0]    viewer_pos_y,
  input  logic signed [15:0]    facing_x,
  input  logic signed [15:0]    facing_y,
  input  logic signed [15:0]    plane_x,
  input  logic signed [15:0]    plane_y,
  input  logic                  crouching,
  input  logic [11:0]           screen_width,
  input  logic [11:0]           screen_height,
  output rsp_side_t             side,
  output logic [DIV_NUM_W-1:0]  depth_num,
  output logic [DIV_DEN_W-1:0]  depth_den,
  output logic [DIV_NUM_W-1:0]  col_num,
  output logic [DIV_DEN_W-1:0]  col_den,
  output logic [DIV_NUM_W-1:0]  size_num,
  output logic [DIV_DEN_W-1:0]  size_den
);

  logic [FRONT_LAT-1:0] vld;
  logic [FRONT_LAT-2:0] snk;

  logic signed [16:0] dx, dy;
  logic signed [15:0] fx1, fy1, px1, py1;
  logic signed [31:0] p_pf, p_fp;
  logic signed [32:0] p_fydx, p_fxdy, p_pxdy, p_pydx;
  logic signed [32:0] det3, det4;
  logic signed [33:0] numx3, numy3, numy4;
  logic signed [34:0] sum4;
  logic [32:0]        det_mag;
  logic [33:0]        numy_mag;
  logic [34:0]        sum_mag;
  logic               neg_depth5, neg_col5, det_zero5;

  // Advance valid and sneak bits with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
    snk <= {snk[FRONT_LAT-3:0], crouching};
  end

  // Offset of the sprite from the viewer, then the six products.
  always_ff @(posedge clk) begin
    dx     <= 17'(sprite_pos_x) - 17'(viewer_pos_x);
    dy     <= 17'(sprite_pos_y) - 17'(viewer_pos_y);
    fx1    <= facing_x;
    fy1    <= facing_y;
    px1    <= plane_x;
    py1    <= plane_y;
    p_pf   <= px1 * fy1;
    p_fp   <= fx1 * py1;
    p_fydx <= fy1 * dx;
    p_fxdy <= fx1 * dy;
    p_pxdy <= px1 * dy;
    p_pydx <= py1 * dx;
  end

  // Determinant and numerators, then the lateral sum.
  always_ff @(posedge clk) begin
    det3  <= 33'(p_pf) - 33'(p_fp);
    numx3 <= 34'(p_fydx) - 34'(p_fxdy);
    numy3 <= 34'(p_pxdy) - 34'(p_pydx);
    det4  <= det3;
    numy4 <= numy3;
    sum4  <= 35'(numy3) + 35'(numx3);
  end

  // Take magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    det_mag    <= det4[32] ? 33'(-det4) : 33'(det4);
    numy_mag   <= numy4[33] ? 34'(-numy4) : 34'(numy4);
    sum_mag    <= sum4[34] ? 35'(-sum4) : 35'(sum4);
    neg_depth5 <= numy4[33] ^ det4[32];
    neg_col5   <= sum4[34] ^ numy4[33];
    det_zero5  <= (det4 == '0);
  end

  // Build the operands of the three divider lanes.
  always_ff @(posedge clk) begin
    depth_num <= {numy_mag, 22'd0};
    depth_den <= DIV_DEN_W'(det_mag);
    col_num   <= DIV_NUM_W'(screen_width[11:1] * sum_mag);
    col_den   <= DIV_DEN_W'(numy_mag);
    size_num  <= DIV_NUM_W'(screen_height * det_mag);
    size_den  <= {numy_mag, 6'd0};
    side.sneak     <= snk[FRONT_LAT-2];
    side.det_zero  <= det_zero5;
    side.neg_depth <= neg_depth5;
    side.neg_col   <= neg_col5;
  end

  assign side.valid = vld[FRONT_LAT-1];

endmodule

### hdl/rsp_div_stage.sv
// One restoring division step: one quotient bit per register stage.
`timescale 1ns / 1ps
module rsp_div_stage import rsp_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  input  logic [DIV_DEN_W-1:0] rem_i,
  output logic [DIV_NUM_W-1:0] num_o,
  output logic [DIV_DEN_W-1:0] den_o,
  output logic [DIV_DEN_W-1:0] rem_o
);

  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_diff;
  logic                 fits;

  // Shift in the next numerator bit and try the subtract.
  always_comb begin
    rem_sh   = {rem_i, num_i[DIV_NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_i};
    fits     = (rem_sh >= {1'b0, den_i});
  end

  // Quotient bits shift in at the bottom of the numerator word.
  always_ff @(posedge clk) begin
    num_o <= {num_i[DIV_NUM_W-2:0], fits};
    den_o <= den_i;
    rem_o <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
  end

endmodule

### hdl/rsp_back.sv
// Back stages: signed quotients, edge clamps, sneak adjust and saturation.
`timescale 1ns / 1ps
module rsp_back import rsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rsp_side_t            side,
  input  logic [DIV_NUM_W-1:0] q_depth,
  input  logic [DIV_NUM_W-1:0] q_col,
  input  logic [DIV_NUM_W-1:0] q_size,
  input  logic [11:0]          screen_width,
  input  logic [11:0]          screen_height,
  output logic                 done,
  output logic [14:0]          rect_left,
  output logic signed [15:0]   rect_width,
  output logic signed [11:0]   rect_top,
  output logic signed [15:0]   rect_height,
  output logic signed [31:0]   depth,
  output logic                 in_front,
  output logic                 degenerate
);

  logic [10:0]        half_w, half_h;
  logic signed [48:0] col_mag, col, hs, x0, x1, x0c_next, x1c_next, w_s;
  logic [48:0]        y1w;
  logic [10:0]        y0_next;
  logic signed [12:0] y1_next;
  logic [31:0]        depth_next;
  logic               degen_next;

  logic               v1, sneak1, degen1, front1;
  logic signed [48:0] x0c, x1c;
  logic [10:0]        y0;
  logic signed [12:0] y1;
  logic [31:0]        depth1;

  logic signed [12:0] y0s, y1s;
  logic [28:0]        y1prod;
  logic signed [49:0] wd;
  logic signed [13:0] hd;

  assign half_w = screen_width[11:1];
  assign half_h = screen_height[11:1];

  // Signed column and half size, clamp the edges, saturate the depth.
  always_comb begin
    col_mag  = $signed({2'b00, q_col[46:0]});
    col      = side.neg_col ? -col_mag : col_mag;
    hs       = $signed({1'b0, q_size[48:1]});
    x0       = col - hs;
    x1       = col + hs;
    w_s      = $signed({37'd0, screen_width});
    x0c_next = x0[48] ? '0 : x0;
    x1c_next = (x1 >= w_s && x0c_next != '0) ? w_s - 49'sd1 : x1;
    y0_next  = (hs > $signed({38'd0, half_h})) ? 11'd0 : half_h - hs[10:0];
    y1w      = {38'd0, half_h} + hs;
    y1_next  = (y1w >= {37'd0, screen_height}) ? $signed({1'b0, screen_height}) - 13'sd1
                                               : $signed(y1w[12:0]);
    if (side.det_zero) begin
      depth_next = '0;
    end else if (!side.neg_depth) begin
      depth_next = (q_depth > 56'd2147483647) ? 32'h7fff_ffff : q_depth[31:0];
    end else begin
      depth_next = (q_depth > 56'd2147483648) ? 32'h8000_0000 : ~q_depth[31:0] + 32'd1;
    end
    degen_next = side.det_zero || (q_depth == '0);
  end

  // Hold the clamped edges for the final stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= side.valid;
    end
    sneak1 <= side.sneak;
    degen1 <= degen_next;
    front1 <= !degen_next && !side.neg_depth;
    x0c    <= x0c_next;
    x1c    <= x1c_next;
    y0     <= y0_next;
    y1     <= y1_next;
    depth1 <= depth_next;
  end

  // Apply sneak offset and scaling, then the differences.
  always_comb begin
    y1prod = 29'({y1[11:0], 1'b0} * DIV5_MULT);
    if (sneak1) begin
      y0s = $signed({2'b00, y0}) - $signed({2'b00, half_w});
      y1s = y1[12] ? 13'sd0 : $signed({2'b00, y1prod[DIV5_SHIFT+10:DIV5_SHIFT]});
    end else begin
      y0s = $signed({2'b00, y0});
      y1s = y1;
    end
    wd = 50'(x1c) - 50'(x0c);
    hd = 14'(y1s) - 14'(y0s);
  end

  // Register the result and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    depth      <= depth1;
    in_front   <= front1;
    degenerate <= degen1;
    if (degen1) begin
      rect_left   <= '0;
      rect_width  <= '0;
      rect_top    <= '0;
      rect_height <= '0;
    end else begin
      rect_left   <= (x0c > 49'sd32767) ? 15'h7fff : x0c[14:0];
      rect_width  <= (wd > 50'sd32767) ? 16'sh7fff :
                     (wd < -50'sd32768) ? 16'sh8000 : wd[15:0];
      rect_top    <= y0s[11:0];
      rect_height <= 16'(hd);
    end
  end

endmodule

### hdl/raycast_sprite_projection_core.sv
// Top level of the sprite projection pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | start / busy         | sprite, viewer, facing, plane, crouching
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//  result   | done (one cycle)     | rect_*, depth, in_front, degenerate
//
// One sprite enters per cycle; busy is always low and cfg_ready always high.
// The pipeline is the 56 stage bit-per-stage divider bank between six operand
// stages and two clamp stages.
// Reset clears all valid bits and loads 640 x 480 into the screen registers.
// The result receiver cannot stall, so nothing in the pipe ever holds.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module raycast_sprite_projection_core import rsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  sprite_pos_x,
  input  logic signed [15:0]  sprite_pos_y,
  input  logic signed [15:0]  viewer_pos_x,
  input  logic signed [15:0]  viewer_pos_y,
  input  logic signed [15:0]  facing_x,
  input  logic signed [15:0]  facing_y,
  input  logic signed [15:0]  plane_x,
  input  logic signed [15:0]  plane_y,
  input  logic                crouching,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  output logic                done,
  output logic [14:0]         rect_left,
  output logic signed [15:0]  rect_width,
  output logic signed [11:0]  rect_top,
  output logic signed [15:0]  rect_height,
  output logic signed [31:0]  depth,
  output logic                in_front,
  output logic                degenerate
);

  logic [11:0] screen_width, screen_height;
  logic        accept;

  logic [DIV_NUM_W-1:0] num_pipe [DIV_LANES][DIV_LAT+1];
  logic [DIV_DEN_W-1:0] den_pipe [DIV_LANES][DIV_LAT+1];
  logic [DIV_DEN_W-1:0] rem_pipe [DIV_LANES][DIV_LAT+1];
  rsp_side_t            side_line [DIV_LAT+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Take configuration transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  rsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .sprite_pos_x  (sprite_pos_x),
    .sprite_pos_y  (sprite_pos_y),
    .viewer_pos_x  (viewer_pos_x),
    .viewer_pos_y  (viewer_pos_y),
    .facing_x      (facing_x),
    .facing_y      (facing_y),
    .plane_x       (plane_x),
    .plane_y       (plane_y),
    .crouching     (crouching),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .side          (side_line[0]),
    .depth_num     (num_pipe[LANE_DEPTH][0]),
    .depth_den     (den_pipe[LANE_DEPTH][0]),
    .col_num       (num_pipe[LANE_COL][0]),
    .col_den       (den_pipe[LANE_COL][0]),
    .size_num      (num_pipe[LANE_SIZE][0]),
    .size_den      (den_pipe[LANE_SIZE][0])
  );

  // Divider bank: three lanes of restoring steps.
  for (genvar ln = 0; ln < DIV_LANES; ln++) begin : g_lane
    assign rem_pipe[ln][0] = '0;
    for (genvar st = 0; st < DIV_LAT; st++) begin : g_step
      rsp_div_stage u_step (
        .clk   (clk),
        .num_i (num_pipe[ln][st]),
        .den_i (den_pipe[ln][st]),
        .rem_i (rem_pipe[ln][st]),
        .num_o (num_pipe[ln][st+1]),
        .den_o (den_pipe[ln][st+1]),
        .rem_o (rem_pipe[ln][st+1])
      );
    end
  end

  // Advance control bits beside the divider lanes.
  for (genvar i = 1; i <= DIV_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_line[i].valid <= 1'b0;
      end else begin
        side_line[i].valid <= side_line[i-1].valid;
      end
      side_line[i].sneak     <= side_line[i-1].sneak;
      side_line[i].det_zero  <= side_line[i-1].det_zero;
      side_line[i].neg_depth <= side_line[i-1].neg_depth;
      side_line[i].neg_col   <= side_line[i-1].neg_col;
    end
  end

  rsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .side          (side_line[DIV_LAT]),
    .q_depth       (num_pipe[LANE_DEPTH][DIV_LAT]),
    .q_col         (num_pipe[LANE_COL][DIV_LAT]),
    .q_size        (num_pipe[LANE_SIZE][DIV_LAT]),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .done          (done),
    .rect_left     (rect_left),
    .rect_width    (rect_width),
    .rect_top      (rect_top),
    .rect_height   (rect_height),
    .depth         (depth),
    .in_front      (in_front),
    .degenerate    (degenerate)
  );

  `RSP_ASSERT(a_result_follows, clk, rst, accept |-> ##PIPE_LAT done, "result missing")
  `RSP_ASSERT(a_no_stray, clk, rst, !accept |-> ##PIPE_LAT !done, "result without transfer")
  `RSP_ASSERT(a_degen_zero, clk, rst, (done && degenerate) |-> (rect_left == '0 && rect_width == '0 && rect_top == '0 && rect_height == '0 && !in_front), "degenerate rect not cleared")
  `RSP_ASSERT(a_front_depth, clk, rst, (done && in_front) |-> (!depth[31] && depth != '0 && !degenerate), "in_front disagrees with depth")
  `RSP_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "strobe after reset")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the sprite projection core.
`timescale 1ns / 1ps
module tb_top;
  import rsp_pkg::*;

  typedef struct {
    logic signed [15:0] spx, spy, vwx, vwy, fcx, fcy, plx, ply;
    logic               crouch;
  } sprite_req_t;

  typedef struct {
    logic [14:0]        left;
    logic signed [15:0] width;
    logic signed [11:0] top;
    logic signed [15:0] height;
    logic signed [31:0] dep;
    logic               front;
    logic               degen;
  } sprite_rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] sprite_pos_x = '0, sprite_pos_y = '0;
  logic signed [15:0] viewer_pos_x = '0, viewer_pos_y = '0;
  logic signed [15:0] facing_x = '0, facing_y = '0, plane_x = '0, plane_y = '0;
  logic crouching = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic done;
  logic [14:0] rect_left;
  logic signed [15:0] rect_width, rect_height;
  logic signed [11:0] rect_top;
  logic signed [31:0] depth;
  logic in_front, degenerate;

  raycast_sprite_projection_core u_top (.*);

  always #2 clk = ~clk;

  sprite_req_t  pending_sprites[$];
  sprite_rect_t expected_rects[$];
  sprite_req_t  cur_sprite;
  longint       scr_w = 640, scr_h = 480;
  bit           taken = 1'b0;
  bit           allow_gaps = 1'b1;
  int           gap_left = 0;
  int           mismatches = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Work out the clamped screen rectangle for one sprite.
  function automatic sprite_rect_t project_sprite(sprite_req_t r);
    sprite_rect_t o;
    longint dx, dy, det, nx, ny, dp, hw, hh, col, sz, hs, y0, y1, x0, x1;
    longint lft, wid, tp, hgt;
    dx = longint'(r.spx) - longint'(r.vwx);
    dy = longint'(r.spy) - longint'(r.vwy);
    det = longint'(r.plx) * r.fcy - longint'(r.fcx) * r.ply;
    nx = longint'(r.fcy) * dx - longint'(r.fcx) * dy;
    ny = longint'(r.plx) * dy - longint'(r.ply) * dx;
    dp = 0;
    if (det != 0) dp = clip((ny * 64'sd4194304) / det, -64'sd2147483648, 64'sd2147483647);
    lft = 0; wid = 0; tp = 0; hgt = 0;
    o.degen = (det == 0) || (dp == 0);
    if (!o.degen) begin
      hw = scr_w / 2;
      hh = scr_h / 2;
      col = (hw * (ny + nx)) / ny;
      sz = (scr_h * det) / (ny * 64);
      if (sz < 0) sz = -sz;
      hs = sz / 2;
      y0 = hh - hs;
      if (y0 < 0) y0 = 0;
      y1 = hh + hs;
      if (y1 >= scr_h) y1 = scr_h - 1;
      x0 = col - hs;
      if (x0 < 0) x0 = 0;
      x1 = col + hs;
      // right edge is clamped only when the left edge moved off zero
      if (x1 >= scr_w && x0 != 0) x1 = scr_w - 1;
      if (r.crouch) begin
        y0 = y0 - hw;
        y1 = (y1 * 2) / 5;
      end
      lft = clip(x0, 0, 32767);
      wid = clip(x1 - x0, -32768, 32767);
      tp = clip(y0, -2048, 2047);
      hgt = clip(y1 - y0, -32768, 32767);
    end
    o.left = lft[14:0];
    o.width = wid[15:0];
    o.top = tp[11:0];
    o.height = hgt[15:0];
    o.dep = dp[31:0];
    o.front = dp > 0;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Pick an idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!allow_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive sprites at the falling edge; hold until the transfer happens.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_sprites.size() > 0) begin
      cur_sprite = pending_sprites.pop_front();
      sprite_pos_x <= cur_sprite.spx;
      sprite_pos_y <= cur_sprite.spy;
      viewer_pos_x <= cur_sprite.vwx;
      viewer_pos_y <= cur_sprite.vwy;
      facing_x <= cur_sprite.fcx;
      facing_y <= cur_sprite.fcy;
      plane_x <= cur_sprite.plx;
      plane_y <= cur_sprite.ply;
      crouching <= cur_sprite.crouch;
      start <= 1'b1;
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // Sample transfers and results at the rising edge.
  always @(posedge clk) begin
    sprite_rect_t w;
    taken = start && !busy && !rst;
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SCREEN_WIDTH) scr_w = cfg_data;
      else if (cfg_index == CFG_SCREEN_HEIGHT) scr_h = cfg_data;
    end
    if (taken) expected_rects.push_back(project_sprite(cur_sprite));
    if (!rst && done) begin
      if (expected_rects.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_rects.pop_front();
        if (rect_left !== w.left) report_mismatch("rect_left", rect_left, w.left);
        if (rect_width !== w.width) report_mismatch("rect_width", rect_width, w.width);
        if (rect_top !== w.top) report_mismatch("rect_top", rect_top, w.top);
        if (rect_height !== w.height) report_mismatch("rect_height", rect_height, w.height);
        if (depth !== w.dep) report_mismatch("depth", depth, w.dep);
        if (in_front !== w.front) report_mismatch("in_front", in_front, w.front);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
      end
    end
  end

  function automatic sprite_req_t mk(int sx, int sy, int vx, int vy,
                                     int fx, int fy, int px, int py, bit c);
    sprite_req_t r;
    r.spx = 16'(sx); r.spy = 16'(sy); r.vwx = 16'(vx); r.vwy = 16'(vy);
    r.fcx = 16'(fx); r.fcy = 16'(fy); r.plx = 16'(px); r.ply = 16'(py); r.crouch = c;
    return r;
  endfunction

  // Random sprite: mostly a plausible camera with a nearby sprite.
  function automatic sprite_req_t rand_sprite();
    sprite_req_t r;
    int fx, fy, k;
    if ($urandom_range(0, 99) < 30) begin
      r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      fx = $signed($urandom_range(0, 32768)) - 16384;
      fy = $signed($urandom_range(0, 32768)) - 16384;
      k = $urandom_range(1, 16);
      r.vwx = 16'($signed($urandom_range(0, 16384)) - 8192);
      r.vwy = 16'($signed($urandom_range(0, 16384)) - 8192);
      r.spx = 16'(r.vwx + ($signed($urandom_range(0, 8192)) - 4096));
      r.spy = 16'(r.vwy + ($signed($urandom_range(0, 8192)) - 4096));
      r.fcx = 16'(fx); r.fcy = 16'(fy);
      r.plx = 16'(-fy * k / 16); r.ply = 16'(fx * k / 16);
      r.crouch = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_sprites.size() > 0 || expected_rects.size() > 0 || start)
      @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  initial begin
    logic [11:0] widths[6], heights[6];
    widths  = '{12'd640, 12'd16, 12'd2048, 12'd4095, 12'd0, 12'd320};
    heights = '{12'd480, 12'd2048, 12'd16, 12'd4095, 12'd0, 12'd200};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners
    pending_sprites.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));            // zero det
    pending_sprites.push_back(mk(256, 256, 256, 256, 0, 16384, 10813, 0, 0)); // zero depth
    pending_sprites.push_back(mk(0, 1280, 0, 0, 0, 16384, 10813, 0, 0));
    pending_sprites.push_back(mk(0, 1280, 0, 0, 0, 16384, 10813, 0, 1));
    pending_sprites.push_back(mk(512, 256, 0, 0, 0, 16384, 10813, 0, 0));
    pending_sprites.push_back(mk(-512, 256, 0, 0, 0, 16384, 10813, 0, 1));
    pending_sprites.push_back(mk(0, -1280, 0, 0, 0, 16384, 10813, 0, 0)); // behind
    pending_sprites.push_back(mk(1, 1, 0, 0, 0, 16384, 10813, 0, 0));   // tiny depth
    pending_sprites.push_back(mk(32767, 32767, -32768, -32768, 32767, 32767,
                                 -32768, 32767, 1));
    pending_sprites.push_back(mk(-32768, -32768, 32767, 32767, -32768, -32768,
                                 32767, -32768, 0));
    pending_sprites.push_back(mk(32767, -32768, -32768, 32767, -32768, 32767,
                                 32767, 32767, 1));
    pending_sprites.push_back(mk(4000, 300, 0, 0, 0, 16384, 10813, 0, 0)); // far right
    pending_sprites.push_back(mk(-4000, 300, 0, 0, 0, 16384, 10813, 0, 0)); // far left
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(CFG_SCREEN_WIDTH, widths[ph]);
        write_reg(CFG_SCREEN_HEIGHT, heights[ph]);
      end
      allow_gaps = (ph != 2);
      for (int i = 0; i < 205; i++) pending_sprites.push_back(rand_sprite());
    end
    drain();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
